[sv/qte_pkg.sv]
// Shared constants, types and the arctangent table for the quaternion to Euler core.
// Used by every module of the block; no dependencies.
`default_nettype none
package qte_pkg;
    localparam int CORDIC_STEPS = 16;
    localparam int MAX_TAB      = 24;
    localparam int NSTEP        = (CORDIC_STEPS < MAX_TAB) ? CORDIC_STEPS : MAX_TAB;
    localparam int QW           = 16;               // component and angle width
    localparam int PW           = 32;               // product width
    localparam int SW           = 35;               // Q28 operand width
    localparam int CW           = 37;               // CORDIC datapath width
    localparam int MW           = 28;               // pitch sine magnitude width
    localparam int RB           = 29;               // square root result bits
    localparam int NW           = 57;               // square root radicand width

    localparam logic signed [SW-1:0] ONE_Q28 = SW'(64'sd268435456);
    localparam logic [31:0]          ACC_PI  = 32'h8000_0000;
    localparam logic [31:0]          ACC_RND = 32'h0000_8000;
    localparam logic [QW-1:0]        ANG_P90 = 16'h4000;
    localparam logic [QW-1:0]        ANG_M90 = 16'hC000;

    localparam logic [31:0] ATAN_TAB [MAX_TAB] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic pos;
        logic neg;
    } t_clamp;

    typedef struct packed {
        logic signed [SW-1:0] sr;
        logic signed [SW-1:0] cr;
        logic signed [SW-1:0] sy;
        logic signed [SW-1:0] cy;
        logic signed [SW-1:0] sp;
        t_clamp               clamp;
    } t_side;
endpackage
`default_nettype wire

[sv/qte_front.sv]
// Front stages: component products, Q28 sine/cosine terms, pitch sine square and clamp.
// Depends on qte_pkg.
`default_nettype none
module qte_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_adv,
    input  wire logic                          i_valid,
    input  wire logic signed [qte_pkg::QW-1:0] i_quat_w,
    input  wire logic signed [qte_pkg::QW-1:0] i_quat_x,
    input  wire logic signed [qte_pkg::QW-1:0] i_quat_y,
    input  wire logic signed [qte_pkg::QW-1:0] i_quat_z,
    output logic                               o_valid,
    output logic [2*qte_pkg::MW-1:0]           o_sq,
    output qte_pkg::t_side                     o_side
);
    import qte_pkg::*;

    logic signed [PW-1:0] r_wx, r_yz, r_xx, r_yy, r_wy, r_zx, r_wz, r_xy, r_zz;
    t_side                r_side2, n_side2, r_side3, n_side3;
    logic [2*MW-1:0]      r_sq;
    logic [2:0]           r_v;
    logic [MW-1:0]        mag;
    logic signed [SW-1:0] neg_sp;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_wx <= i_quat_w * i_quat_x;
            r_yz <= i_quat_y * i_quat_z;
            r_xx <= i_quat_x * i_quat_x;
            r_yy <= i_quat_y * i_quat_y;
            r_wy <= i_quat_w * i_quat_y;
            r_zx <= i_quat_z * i_quat_x;
            r_wz <= i_quat_w * i_quat_z;
            r_xy <= i_quat_x * i_quat_y;
            r_zz <= i_quat_z * i_quat_z;
        end
    end

    always_comb begin
        n_side2.sr = (SW'(r_wx) + SW'(r_yz)) <<< 1;
        n_side2.cr = ONE_Q28 - ((SW'(r_xx) + SW'(r_yy)) <<< 1);
        n_side2.sp = (SW'(r_wy) - SW'(r_zx)) <<< 1;
        n_side2.sy = (SW'(r_wz) + SW'(r_xy)) <<< 1;
        n_side2.cy = ONE_Q28 - ((SW'(r_yy) + SW'(r_zz)) <<< 1);
        n_side2.clamp.pos = 1'b0;
        n_side2.clamp.neg = 1'b0;
    end

    always_comb begin
        n_side3           = r_side2;
        n_side3.clamp.pos = (r_side2.sp >= ONE_Q28);
        n_side3.clamp.neg = (r_side2.sp <= -ONE_Q28);
    end

    // sine magnitude is only meaningful below one; clamped words ignore the square
    assign neg_sp = -r_side2.sp;
    assign mag    = r_side2.sp[SW-1] ? neg_sp[MW-1:0] : r_side2.sp[MW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_side2 <= n_side2;
            r_side3 <= n_side3;
            r_sq    <= mag * mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_adv) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    assign o_valid = r_v[2];
    assign o_sq    = r_sq;
    assign o_side  = r_side3;
endmodule
`default_nettype wire

[sv/qte_sqrt.sv]
// Pipelined digit-by-digit square root of 2^56 minus the pitch sine square, one bit a stage.
// Carries the side terms alongside. Depends on qte_pkg.
`default_nettype none
module qte_sqrt (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_adv,
    input  wire logic                     i_valid,
    input  wire logic [2*qte_pkg::MW-1:0] i_sq,
    input  qte_pkg::t_side                i_side,
    output logic                          o_valid,
    output logic [qte_pkg::RB-1:0]        o_root,
    output qte_pkg::t_side                o_side
);
    import qte_pkg::*;

    localparam logic [NW-1:0] TOP = NW'(1) << (2*MW);

    logic [NW-1:0] r_n   [RB+1];
    logic [NW-1:0] r_res [RB+1];
    t_side         r_side[RB+1];
    logic [RB:0]   r_v;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_n[0]    <= TOP - NW'(i_sq);
            r_res[0]  <= '0;
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 0; k < RB; k++) begin : g_stage
        localparam int            B    = 2*(RB-1-k);
        localparam logic [NW-1:0] BITV = NW'(1) << B;
        logic [NW-1:0] trial;
        logic [NW-1:0] n_n, n_res;
        always_comb begin
            trial = r_res[k] + BITV;
            if (r_n[k] >= trial) begin
                n_n   = r_n[k] - trial;
                n_res = (r_res[k] >> 1) + BITV;
            end else begin
                n_n   = r_n[k];
                n_res = r_res[k] >> 1;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_n[k+1]    <= n_n;
                r_res[k+1]  <= n_res;
                r_side[k+1] <= r_side[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_adv) begin
            r_v <= {r_v[RB-1:0], i_valid};
        end
    end

    assign o_valid = r_v[RB];
    assign o_root  = r_res[RB][RB-1:0];
    assign o_side  = r_side[RB];
endmodule
`default_nettype wire

[sv/qte_cordic.sv]
// Pipelined vectoring CORDIC: atan2(y, x) as a 16-bit binary angle, one iteration a stage.
// Optional clamp forces +-pi/2. Depends on qte_pkg.
`default_nettype none
module qte_cordic (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_adv,
    input  wire logic                          i_valid,
    input  wire logic signed [qte_pkg::SW-1:0] i_y,
    input  wire logic signed [qte_pkg::SW-1:0] i_x,
    input  qte_pkg::t_clamp                    i_clamp,
    output logic                               o_valid,
    output logic [qte_pkg::QW-1:0]             o_angle
);
    import qte_pkg::*;

    logic signed [CW-1:0] r_x   [NSTEP+1];
    logic signed [CW-1:0] r_y   [NSTEP+1];
    logic [31:0]          r_acc [NSTEP+1];
    logic                 r_zero[NSTEP+1];
    t_clamp               r_cl  [NSTEP+1];
    logic [NSTEP+1:0]     r_v;
    logic [QW-1:0]        r_angle, n_angle;
    logic [31:0]          rnd;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_zero[0] <= (i_x == '0) && (i_y == '0);
            r_cl[0]   <= i_clamp;
            // fold the left half plane onto the right
            if (i_x < 0) begin
                r_x[0]   <= -CW'(i_x);
                r_y[0]   <= -CW'(i_y);
                r_acc[0] <= ACC_PI;
            end else begin
                r_x[0]   <= CW'(i_x);
                r_y[0]   <= CW'(i_y);
                r_acc[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < NSTEP; i++) begin : g_iter
        logic signed [CW-1:0] xs, ys;
        assign xs = r_x[i] >>> i;
        assign ys = r_y[i] >>> i;
        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                if (!r_y[i][CW-1]) begin
                    r_x[i+1]   <= r_x[i] + ys;
                    r_y[i+1]   <= r_y[i] - xs;
                    r_acc[i+1] <= r_acc[i] + ATAN_TAB[i];
                end else begin
                    r_x[i+1]   <= r_x[i] - ys;
                    r_y[i+1]   <= r_y[i] + xs;
                    r_acc[i+1] <= r_acc[i] - ATAN_TAB[i];
                end
                r_zero[i+1] <= r_zero[i];
                r_cl[i+1]   <= r_cl[i];
            end
        end
    end

    assign rnd = r_acc[NSTEP] + ACC_RND;

    always_comb begin
        if (r_cl[NSTEP].pos) begin
            n_angle = ANG_P90;
        end else if (r_cl[NSTEP].neg) begin
            n_angle = ANG_M90;
        end else if (r_zero[NSTEP]) begin
            n_angle = '0;
        end else begin
            n_angle = rnd[31:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_angle <= n_angle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_adv) begin
            r_v <= {r_v[NSTEP:0], i_valid};
        end
    end

    assign o_valid = r_v[NSTEP+1];
    assign o_angle = r_angle;
endmodule
`default_nettype wire

[sv/quaternion_to_euler_angles_core.sv]
// Quaternion (Q1.14) to roll, pitch and yaw binary angles, fully pipelined.
// Instantiates qte_front, qte_sqrt and three qte_cordic; depends on qte_pkg.
//
// Input channel: i_valid / o_stall with one quaternion word (w, x, y, z).
// A word is taken at a rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall with one angle word (roll, pitch, yaw).
// Pipeline: 3 front stages, 30 square root stages and 18 CORDIC stages
// (entry fold, 16 iterations, output round) from acceptance to o_valid.
// Throughput: one word per cycle unless held (see Stall); every stage is a
// register set, so earlier words move down the pipe as new ones enter.
// Stall: while o_valid is high and i_stall is high the whole pipe holds and
// o_stall is raised; bubbles are not squeezed out during a hold. The held
// output word stays unchanged until taken.
// Reset: synchronous, active low; clears all valid bits, the pipe is empty
// and ready on the first cycle after reset.
`default_nettype none
module quaternion_to_euler_angles_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic signed [qte_pkg::QW-1:0] i_quat_w,
    input  wire logic signed [qte_pkg::QW-1:0] i_quat_x,
    input  wire logic signed [qte_pkg::QW-1:0] i_quat_y,
    input  wire logic signed [qte_pkg::QW-1:0] i_quat_z,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic signed [qte_pkg::QW-1:0]      o_roll_angle,
    output logic signed [qte_pkg::QW-1:0]      o_pitch_angle,
    output logic signed [qte_pkg::QW-1:0]      o_yaw_angle
);
    import qte_pkg::*;

    logic            adv;
    logic            f_valid, s_valid;
    logic [2*MW-1:0] f_sq;
    t_side           f_side, s_side;
    logic [RB-1:0]   s_root;
    t_clamp          no_clamp;
    logic [QW-1:0]   roll, pitch, yaw;

    // advance whenever the output slot is empty or being taken
    assign adv      = !o_valid || !i_stall;
    assign o_stall  = !adv;
    assign no_clamp = '{pos: 1'b0, neg: 1'b0};

    qte_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (i_valid),
        .i_quat_w(i_quat_w),
        .i_quat_x(i_quat_x),
        .i_quat_y(i_quat_y),
        .i_quat_z(i_quat_z),
        .o_valid (f_valid),
        .o_sq    (f_sq),
        .o_side  (f_side)
    );

    qte_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (f_valid),
        .i_sq    (f_sq),
        .i_side  (f_side),
        .o_valid (s_valid),
        .o_root  (s_root),
        .o_side  (s_side)
    );

    qte_cordic u_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (s_valid),
        .i_y     (s_side.sr),
        .i_x     (s_side.cr),
        .i_clamp (no_clamp),
        .o_valid (),
        .o_angle (roll)
    );

    qte_cordic u_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (s_valid),
        .i_y     (s_side.sp),
        .i_x     (SW'(s_root)),
        .i_clamp (s_side.clamp),
        .o_valid (o_valid),
        .o_angle (pitch)
    );

    qte_cordic u_yaw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (s_valid),
        .i_y     (s_side.sy),
        .i_x     (s_side.cy),
        .i_clamp (no_clamp),
        .o_valid (),
        .o_angle (yaw)
    );

    assign o_roll_angle  = roll;
    assign o_pitch_angle = pitch;
    assign o_yaw_angle   = yaw;
endmodule
`default_nettype wire

[verif/qte_checker.sv]
// Checker for the quaternion to Euler core: watches both channels, predicts angles.
// Depends on qte_pkg for widths and the arctangent table.
`default_nettype none
module qte_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic                          i_in_stall,
    input  wire logic signed [qte_pkg::QW-1:0] i_quat_w,
    input  wire logic signed [qte_pkg::QW-1:0] i_quat_x,
    input  wire logic signed [qte_pkg::QW-1:0] i_quat_y,
    input  wire logic signed [qte_pkg::QW-1:0] i_quat_z,
    input  wire logic                          i_out_valid,
    input  wire logic                          i_out_stall,
    input  wire logic signed [qte_pkg::QW-1:0] i_roll_angle,
    input  wire logic signed [qte_pkg::QW-1:0] i_pitch_angle,
    input  wire logic signed [qte_pkg::QW-1:0] i_yaw_angle,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    import qte_pkg::*;

    typedef struct packed {
        logic [QW-1:0] roll;
        logic [QW-1:0] pitch;
        logic [QW-1:0] yaw;
    } t_angles;

    t_angles angle_fifo [$];

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic [QW-1:0] vector_angle(longint yv, longint xv);
        logic [31:0] acc;
        longint      xs;
        longint      ys;
        acc = '0;
        if (xv == 0 && yv == 0) return '0;
        if (xv < 0) begin
            xv  = -xv;
            yv  = -yv;
            acc = ACC_PI;
        end
        for (int i = 0; i < NSTEP; i++) begin
            xs = floor_shift(xv, i);
            ys = floor_shift(yv, i);
            if (yv >= 0) begin
                xv  = xv + ys;
                yv  = yv - xs;
                acc = acc + ATAN_TAB[i];
            end else begin
                xv  = xv - ys;
                yv  = yv + xs;
                acc = acc - ATAN_TAB[i];
            end
        end
        acc = acc + ACC_RND;
        return acc[31:16];
    endfunction

    function automatic longint floor_root(longint n);
        longint r;
        longint b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > n) b = b >>> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic t_angles euler_angles(longint w, longint x, longint y, longint z);
        t_angles a;
        longint  one;
        longint  sp;
        one = 64'sd1 <<< 28;
        sp  = 2 * (w * y - z * x);
        a.roll = vector_angle(2 * (w * x + y * z), one - 2 * (x * x + y * y));
        a.yaw  = vector_angle(2 * (w * z + x * y), one - 2 * (y * y + z * z));
        if (sp >= one) a.pitch = ANG_P90;
        else if (sp <= -one) a.pitch = ANG_M90;
        else a.pitch = vector_angle(sp, floor_root((64'sd1 <<< 56) - sp * sp));
        return a;
    endfunction

    always @(posedge i_clk) begin
        t_angles got;
        t_angles want;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (i_in_valid && !i_in_stall)
                angle_fifo.push_back(euler_angles(i_quat_w, i_quat_x, i_quat_y, i_quat_z));
            if (i_out_valid && !i_out_stall) begin
                got = '{i_roll_angle, i_pitch_angle, i_yaw_angle};
                if (angle_fifo.size() == 0) begin
                    $display("%0t: unexpected word %h", $time, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = angle_fifo.pop_front();
                    if (got.roll != want.roll || got.pitch != want.pitch
                            || got.yaw != want.yaw) begin
                        $display("%0t: mismatch expected r/p/y %0d %0d %0d actual %0d %0d %0d",
                            $time, $signed(want.roll), $signed(want.pitch), $signed(want.yaw),
                            $signed(got.roll), $signed(got.pitch), $signed(got.yaw));
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending <= angle_fifo.size();
    end
endmodule
`default_nettype wire

[verif/tb.sv]
// Top of the quaternion to Euler regression: clock, reset, stimulus and verdict.
// Depends on qte_pkg, quaternion_to_euler_angles_core and qte_checker.
`default_nettype none
module tb;
    import qte_pkg::*;

    localparam int N_RANDOM   = 1700;
    localparam int LATENCY    = 3 + 30 + NSTEP + 2;
    localparam int IDLE_LIMIT = 2000;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic signed [QW-1:0] qw, qx, qy, qz;
    logic                 out_valid;
    logic                 out_stall;
    logic signed [QW-1:0] roll, pitch, yaw;
    int                   fail_count;
    int                   pending;
    int                   idle_cycles;

    quaternion_to_euler_angles_core dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_quat_w(qw), .i_quat_x(qx), .i_quat_y(qy), .i_quat_z(qz),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_roll_angle(roll), .o_pitch_angle(pitch), .o_yaw_angle(yaw)
    );

    qte_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_quat_w(qw), .i_quat_x(qx), .i_quat_y(qy), .i_quat_z(qz),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_roll_angle(roll), .i_pitch_angle(pitch), .i_yaw_angle(yaw),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        clk = 1'b1; #5;
        clk = 1'b0; #5;
    end

    function automatic logic signed [QW-1:0] rand_comp();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) return QW'($urandom);
        if (r == 1) return ($urandom_range(0, 1) != 0 ? 16'sd16384 : -16'sd16384);
        return QW'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    // Build a near-unit quaternion from random direction.
    task automatic unit_quat(output logic signed [QW-1:0] w, x, y, z);
        real a, b, c, d, n;
        a = $signed($urandom_range(0, 2000)) - 1000;
        b = $signed($urandom_range(0, 2000)) - 1000;
        c = $signed($urandom_range(0, 2000)) - 1000;
        d = $signed($urandom_range(0, 2000)) - 1000;
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n == 0.0) begin
            a = 1.0; n = 1.0;
        end
        w = QW'($rtoi(a / n * 16384.0));
        x = QW'($rtoi(b / n * 16384.0));
        y = QW'($rtoi(c / n * 16384.0));
        z = QW'($rtoi(d / n * 16384.0));
    endtask

    task automatic send_word(logic signed [QW-1:0] w, x, y, z);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        qw <= w; qx <= x; qy <= y; qz <= z;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    // Receiver: stall a random count of cycles per word, with quiet stretches.
    always @(negedge clk) begin
        int hold;
        if (!rst_n) begin
            out_stall <= 1'b0;
            hold = 0;
        end else if (hold > 0) begin
            hold--;
            out_stall <= (hold != 0);
        end else if (out_valid && $urandom_range(0, 2) != 0) begin
            hold = $urandom_range(0, 17);
            out_stall <= (hold > 0);
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        logic signed [QW-1:0] w, x, y, z;
        int                   tail;
        rst_n = 1'b0; in_valid = 1'b0; out_stall = 1'b0; idle_cycles = 0;
        qw = '0; qx = '0; qy = '0; qz = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // identity, zero quaternion, near gimbal lock both signs, pitch clamp, extremes
        send_word(16'sd16384, 0, 0, 0);
        send_word(0, 0, 0, 0);
        send_word(11585, 0, 11585, 0);
        send_word(11585, 0, -11585, 0);
        send_word(16'sd16384, 0, 16'sd16384, 0);
        send_word(0, 16'sd16384, 0, 0);
        send_word(0, 0, 0, 16'sd16384);
        send_word(0, -16'sd16384, 0, 0);
        send_word(-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384);
        send_word(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send_word(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
        send_word(16'sh8000, 16'sd32767, 16'sh8000, 16'sd32767);
        send_word(0, 16'sd16384, 16'sd16384, 0);
        send_word(11585, 11585, 0, 0);
        send_word(-1, -1, -1, -1);

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM / 2) begin
                // drain the pipe once before carrying on
                in_valid <= 1'b0;
                while (pending != 0) @(negedge clk);
            end
            if ($urandom_range(0, 3) == 0) begin
                w = rand_comp(); x = rand_comp(); y = rand_comp(); z = rand_comp();
            end else begin
                unit_quat(w, x, y, z);
            end
            send_word(w, x, y, z);
        end
        in_valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        tail = 0;
        while (tail < 2 * LATENCY) begin
            @(posedge clk);
            tail++;
        end
        if (fail_count == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire
